### hdl/hpr_pkg.sv
// Shared types and constants of the hashed point registry store.
// Used by every module of the block but hpr_ram; depends on nothing else.
package hpr_pkg;

  localparam int unsigned CAP_W      = 11;
  localparam int unsigned SLOT_W     = 10;
  localparam int unsigned HASH_W     = 15;  // masked hash never exceeds 15 bits
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned PADDR_W    = 5;
  localparam int unsigned FMIX_SHIFT = 33;
  localparam logic [63:0] FMIX_C1    = 64'hff51afd7ed558ccd;
  localparam logic [63:0] FMIX_C2    = 64'hc4ceb9fe1a85ec53;

  typedef enum logic [1:0] {
    CMD_REGISTER = 2'd0,
    CMD_FIND     = 2'd1,
    CMD_WRITE    = 2'd2,
    CMD_READ     = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_BINARY   = 2'd0,
    KIND_ANALOG   = 2'd1,
    KIND_SETPOINT = 2'd2,
    KIND_CONTROL  = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_EXISTS  = 3'd1,
    ST_FULL    = 3'd2,
    ST_MISSING = 3'd3,
    ST_KIND    = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    REG_BINARY_CAP   = 3'd0,
    REG_ANALOG_CAP   = 3'd1,
    REG_SETPOINT_CAP = 3'd2,
    REG_CONTROL_CAP  = 3'd3,
    REG_BUCKET_BITS  = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic [1:0]  command;
    logic [63:0] key;
    logic [1:0]  point_kind;
    logic [31:0] point_value;
    logic [63:0] stamp;
    logic [7:0]  quality_in;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [1:0]  kind_out;
    logic [9:0]  slot_out;
    logic [31:0] value_out;
    logic [63:0] stamp_out;
    logic [7:0]  quality_out;
  } rsp_t;

  typedef struct packed {
    req_t              req;
    logic [HASH_W-1:0] bucket;
  } item_t;

  typedef struct packed {
    logic [3:0][CAP_W-1:0] capacity;
    logic [3:0]            bucket_bits;
  } cfg_t;

  typedef struct packed {
    logic clearing;
  } back_stat_t;

endpackage

### hdl/hpr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package use.
module hpr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

### hdl/hpr_queue.sv
// Short item queue between the hashing front and the chain-walking back.
// Uses hpr_pkg for the item type and depth.
module hpr_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  hpr_pkg::item_t push_item_i,
  output logic          full_o,
  input  logic          pop_i,
  output hpr_pkg::item_t head_o,
  output logic          empty_o
);
  localparam int unsigned Depth = hpr_pkg::QUEUE_DEPTH;
  localparam int unsigned PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  hpr_pkg::item_t slots_q [Depth];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [CntW-1:0] count_q;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign head_o  = slots_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) begin
      slots_q[wptr_q] <= push_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (push_i && !full_o) begin
        wptr_q <= (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (pop_i && !empty_o) begin
        rptr_q <= (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + 1'b1;
      end
      count_q <= count_q + CntW'(push_i && !full_o) - CntW'(pop_i && !empty_o);
    end
  end
endmodule

### hdl/hpr_front.sv
// Front end: accepts commands, hashes the key (murmur3 64-bit finalizer) on
// one shared 32x32 multiplier, reduces it to a bucket and queues the item.
// Uses hpr_pkg.
module hpr_front #(
  parameter int unsigned BUCKET_DEPTH = 2048
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  hpr_pkg::req_t       req_i,
  output logic                busy_o,
  input  logic [3:0]          bucket_bits_i,
  input  hpr_pkg::back_stat_t back_stat_i,
  output logic                push_o,
  output hpr_pkg::item_t      push_item_o,
  input  logic                full_i
);
  localparam int unsigned HW = hpr_pkg::HASH_W;
  localparam logic [63:0] RecipL = 64'h1_0000_0000 / 64'(BUCKET_DEPTH);
  localparam logic [31:0] Recip  = RecipL[31:0];
  localparam logic [31:0] DepthW = 32'(BUCKET_DEPTH);

  typedef enum logic [4:0] {
    F_IDLE  = 5'b00001,
    F_MUL   = 5'b00010,
    F_MOD_Q = 5'b00100,
    F_MOD_R = 5'b01000,
    F_PUSH  = 5'b10000
  } fstate_e;

  fstate_e         state_q, state_d;
  hpr_pkg::req_t   item_q, item_d;
  logic [63:0]     acc_q, acc_d, p0_q, p0_d;
  logic [31:0]     cross_q, cross_d;
  logic [1:0]      mstep_q, mstep_d;
  logic            round_q, round_d;
  logic [HW-1:0]   xm_q, xm_d, quo_q, quo_d, rem_q, rem_d;

  logic [31:0]     mul_a, mul_b;
  logic [63:0]     prod, full_prod, mixed, konst;
  logic [HW-1:0]   mask, xmask;
  logic [31:0]     rem_ext, bucket_w;
  logic            accept;

  assign konst     = round_q ? hpr_pkg::FMIX_C2 : hpr_pkg::FMIX_C1;
  assign prod      = mul_a * mul_b;
  assign full_prod = p0_q + {cross_q, 32'h0};
  assign mixed     = full_prod ^ (full_prod >> hpr_pkg::FMIX_SHIFT);
  assign mask      = HW'((32'd1 << bucket_bits_i) - 32'd1);
  assign xmask     = acc_q[HW-1:0] & mask;
  assign rem_ext   = {{(32 - HW){1'b0}}, rem_q};
  assign bucket_w  = (rem_ext >= DepthW) ? rem_ext - DepthW : rem_ext;

  assign accept = start_i && (state_q == F_IDLE) && !back_stat_i.clearing;
  assign busy_o = (state_q != F_IDLE) || back_stat_i.clearing;

  assign push_item_o.req    = item_q;
  assign push_item_o.bucket = bucket_w[HW-1:0];
  assign push_o             = (state_q == F_PUSH) && !full_i;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      F_MUL: begin
        case (mstep_q)
          2'd0: begin
            mul_a = acc_q[31:0];
            mul_b = konst[31:0];
          end
          2'd1: begin
            mul_a = acc_q[63:32];
            mul_b = konst[31:0];
          end
          2'd2: begin
            mul_a = acc_q[31:0];
            mul_b = konst[63:32];
          end
          default: begin
            mul_a = '0;
            mul_b = '0;
          end
        endcase
      end
      F_MOD_Q: begin
        mul_a = {{(32 - HW){1'b0}}, xmask};
        mul_b = Recip;
      end
      F_MOD_R: begin
        mul_a = {{(32 - HW){1'b0}}, quo_q};
        mul_b = DepthW;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    item_d  = item_q;
    acc_d   = acc_q;
    p0_d    = p0_q;
    cross_d = cross_q;
    mstep_d = mstep_q;
    round_d = round_q;
    xm_d    = xm_q;
    quo_d   = quo_q;
    rem_d   = rem_q;
    unique case (state_q)
      F_IDLE: begin
        if (accept) begin
          item_d  = req_i;
          acc_d   = req_i.key ^ (req_i.key >> hpr_pkg::FMIX_SHIFT);
          mstep_d = '0;
          round_d = 1'b0;
          state_d = F_MUL;
        end
      end
      F_MUL: begin
        mstep_d = mstep_q + 2'd1;
        case (mstep_q)
          2'd0: p0_d = prod;
          2'd1: cross_d = prod[31:0];
          2'd2: cross_d = cross_q + prod[31:0];
          default: begin
            // low 64 bits of the product are complete; mix and go on
            acc_d = mixed;
            if (round_q) begin
              state_d = F_MOD_Q;
            end else begin
              round_d = 1'b1;
            end
          end
        endcase
      end
      F_MOD_Q: begin
        xm_d    = xmask;
        quo_d   = prod[32 +: HW];
        state_d = F_MOD_R;
      end
      F_MOD_R: begin
        // quotient estimate is low by at most one: remainder stays below 2*depth
        rem_d   = xm_q - prod[HW-1:0];
        state_d = F_PUSH;
      end
      F_PUSH: begin
        if (!full_i) begin
          state_d = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    item_q  <= item_d;
    acc_q   <= acc_d;
    p0_q    <= p0_d;
    cross_q <= cross_d;
    xm_q    <= xm_d;
    quo_q   <= quo_d;
    rem_q   <= rem_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      mstep_q <= '0;
      round_q <= 1'b0;
    end else begin
      state_q <= state_d;
      mstep_q <= mstep_d;
      round_q <= round_d;
    end
  end
endmodule

### hdl/hpr_back.sv
// Back end: clears the bucket heads after reset, walks hash chains and
// executes register, find, write and read against the entry and point RAMs.
// Uses hpr_pkg and hpr_ram.
module hpr_back #(
  parameter int unsigned MAX_ENTRIES  = 1024,
  parameter int unsigned BUCKET_DEPTH = 2048
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  hpr_pkg::cfg_t       cfg_i,
  input  hpr_pkg::item_t      head_i,
  input  logic                empty_i,
  output logic                pop_o,
  output hpr_pkg::back_stat_t stat_o,
  output logic                done_o,
  output hpr_pkg::rsp_t       result_o
);
  localparam int unsigned EW  = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned AW  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned BW  = (BUCKET_DEPTH > 1) ? $clog2(BUCKET_DEPTH) : 1;
  localparam int unsigned CW  = hpr_pkg::CAP_W;
  localparam int unsigned SW  = hpr_pkg::SLOT_W;
  localparam int unsigned EDW = 64 + 2 + SW + EW;
  localparam int unsigned PDW = 32 + 64 + 8;

  typedef enum logic [5:0] {
    B_CLEAR  = 6'b000001,
    B_IDLE   = 6'b000010,
    B_HEAD   = 6'b000100,
    B_ENTRY  = 6'b001000,
    B_DECIDE = 6'b010000,
    B_READ   = 6'b100000
  } bstate_e;

  bstate_e              state_q, state_d;
  hpr_pkg::item_t       item_q, item_d;
  logic [EW-1:0]        total_q, total_d;
  logic [3:0][CW-1:0]   fill_q, fill_d;
  logic [EW-1:0]        head_q, head_d, cur_q, cur_d, hit_q, hit_d;
  logic [1:0]           hkind_q, hkind_d;
  logic [SW-1:0]        hslot_q, hslot_d;
  logic [BW-1:0]        clr_q, clr_d;
  logic                 done_q, done_d;
  hpr_pkg::rsp_t        rsp_q, rsp_d;

  logic                 bk_we, ent_we, pt_we;
  logic [BW-1:0]        bk_waddr, bk_raddr;
  logic [EW-1:0]        bk_wdata, bk_rdata;
  logic [AW-1:0]        ent_waddr, ent_raddr, pt_waddr, pt_raddr;
  logic [EDW-1:0]       ent_wdata, ent_rdata;
  logic [PDW-1:0]       pt_wdata, pt_rdata;

  logic [63:0]          ent_key;
  logic [1:0]           ent_kind;
  logic [SW-1:0]        ent_slot;
  logic [EW-1:0]        ent_link, n_cand, n_less;
  logic                 n_ok;
  logic [1:0]           kind;
  logic [CW-1:0]        cap_k, fill_k;
  logic [31:0]          wr_value;

  assign ent_key  = ent_rdata[EDW-1 -: 64];
  assign ent_kind = ent_rdata[EW+SW +: 2];
  assign ent_slot = ent_rdata[EW +: SW];
  assign ent_link = ent_rdata[EW-1:0];

  assign kind     = item_q.req.point_kind;
  assign cap_k    = cfg_i.capacity[kind];
  assign fill_k   = fill_q[kind];
  assign wr_value = (kind == hpr_pkg::KIND_BINARY || kind == hpr_pkg::KIND_CONTROL)
                    ? {24'h0, item_q.req.point_value[7:0]} : item_q.req.point_value;

  assign n_cand    = (state_q == B_HEAD) ? bk_rdata : ent_link;
  assign n_ok      = (n_cand != '0) && (n_cand <= total_q);
  assign n_less    = n_cand - 1'b1;
  assign ent_raddr = n_less[AW-1:0];
  assign bk_raddr  = BW'(head_i.bucket);

  assign pop_o          = (state_q == B_IDLE) && !empty_i;
  assign stat_o.clearing = (state_q == B_CLEAR);
  assign done_o         = done_q;
  assign result_o       = rsp_q;

  hpr_ram #(.WIDTH(EW), .DEPTH(BUCKET_DEPTH)) u_bucket_ram (
    .clk_i   (clk_i),
    .we_i    (bk_we),
    .waddr_i (bk_waddr),
    .wdata_i (bk_wdata),
    .raddr_i (bk_raddr),
    .rdata_o (bk_rdata)
  );

  hpr_ram #(.WIDTH(EDW), .DEPTH(MAX_ENTRIES)) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ent_we),
    .waddr_i (ent_waddr),
    .wdata_i (ent_wdata),
    .raddr_i (ent_raddr),
    .rdata_o (ent_rdata)
  );

  hpr_ram #(.WIDTH(PDW), .DEPTH(MAX_ENTRIES)) u_point_ram (
    .clk_i   (clk_i),
    .we_i    (pt_we),
    .waddr_i (pt_waddr),
    .wdata_i (pt_wdata),
    .raddr_i (pt_raddr),
    .rdata_o (pt_rdata)
  );

  always_comb begin
    logic [EW-1:0] hit_less;
    hit_less  = hit_q - 1'b1;
    state_d   = state_q;
    item_d    = item_q;
    total_d   = total_q;
    fill_d    = fill_q;
    head_d    = head_q;
    cur_d     = cur_q;
    hit_d     = hit_q;
    hkind_d   = hkind_q;
    hslot_d   = hslot_q;
    clr_d     = clr_q;
    done_d    = 1'b0;
    rsp_d     = rsp_q;
    bk_we     = 1'b0;
    bk_waddr  = BW'(item_q.bucket);
    bk_wdata  = total_q + 1'b1;
    ent_we    = 1'b0;
    ent_waddr = total_q[AW-1:0];
    ent_wdata = {item_q.req.key, kind, fill_k[SW-1:0], head_q};
    pt_we     = 1'b0;
    pt_waddr  = hit_less[AW-1:0];
    pt_wdata  = {wr_value, item_q.req.stamp, item_q.req.quality_in};
    pt_raddr  = hit_less[AW-1:0];
    unique case (state_q)
      B_CLEAR: begin
        bk_we    = 1'b1;
        bk_waddr = clr_q;
        bk_wdata = '0;
        clr_d    = clr_q + 1'b1;
        if (clr_q == BW'(BUCKET_DEPTH - 1)) begin
          state_d = B_IDLE;
        end
      end
      B_IDLE: begin
        if (!empty_i) begin
          item_d  = head_i;
          state_d = B_HEAD;
        end
      end
      B_HEAD: begin
        head_d = bk_rdata;
        hit_d  = '0;
        cur_d  = n_cand;
        state_d = n_ok ? B_ENTRY : B_DECIDE;
      end
      B_ENTRY: begin
        if (ent_key == item_q.req.key) begin
          hit_d   = cur_q;
          hkind_d = ent_kind;
          hslot_d = ent_slot;
          state_d = B_DECIDE;
        end else begin
          // follow the link to the next older entry of this bucket
          cur_d   = n_cand;
          state_d = n_ok ? B_ENTRY : B_DECIDE;
        end
      end
      B_DECIDE: begin
        rsp_d       = '0;
        rsp_d.status = hpr_pkg::ST_OK;
        if (hit_q != '0) begin
          rsp_d.kind_out = hkind_q;
          rsp_d.slot_out = hslot_q;
        end
        done_d  = 1'b1;
        state_d = B_IDLE;
        if (item_q.req.command == hpr_pkg::CMD_REGISTER) begin
          if (hit_q != '0) begin
            rsp_d.status = hpr_pkg::ST_EXISTS;
          end else if (fill_k >= cap_k || total_q >= EW'(MAX_ENTRIES)) begin
            rsp_d.status = hpr_pkg::ST_FULL;
          end else begin
            ent_we   = 1'b1;
            bk_we    = 1'b1;
            pt_we    = 1'b1;
            pt_waddr = total_q[AW-1:0];
            pt_wdata = '0;
            fill_d[kind]   = fill_k + 1'b1;
            total_d        = total_q + 1'b1;
            rsp_d.kind_out = kind;
            rsp_d.slot_out = fill_k[SW-1:0];
          end
        end else if (hit_q == '0) begin
          rsp_d.status = hpr_pkg::ST_MISSING;
        end else if (item_q.req.command == hpr_pkg::CMD_WRITE ||
                     item_q.req.command == hpr_pkg::CMD_READ) begin
          if (hkind_q != kind || {1'b0, hslot_q} >= cap_k) begin
            rsp_d.status = hpr_pkg::ST_KIND;
          end else if (item_q.req.command == hpr_pkg::CMD_WRITE) begin
            pt_we = 1'b1;
          end else begin
            // hold the result back until the registered point RAM read data is there in B_READ
            done_d  = 1'b0;
            state_d = B_READ;
          end
        end
      end
      B_READ: begin
        rsp_d.value_out   = pt_rdata[PDW-1 -: 32];
        rsp_d.stamp_out   = pt_rdata[8 +: 64];
        rsp_d.quality_out = pt_rdata[7:0];
        done_d  = 1'b1;
        state_d = B_IDLE;
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    item_q  <= item_d;
    head_q  <= head_d;
    cur_q   <= cur_d;
    hit_q   <= hit_d;
    hkind_q <= hkind_d;
    hslot_q <= hslot_d;
    rsp_q   <= rsp_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_CLEAR;
      total_q <= '0;
      fill_q  <= '0;
      clr_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      total_q <= total_d;
      fill_q  <= fill_d;
      clr_q   <= clr_d;
      done_q  <= done_d;
    end
  end
endmodule

### hdl/hashed_point_registry_store.sv
// Top level of the hashed point registry store: APB register file, front,
// queue and back. Uses hpr_pkg, hpr_front, hpr_queue and hpr_back.
//
// Usage: drive a command on req_i with start high; it is taken at a rising
// edge where busy is low. The front hashes the key with the murmur3 64-bit
// finalizer on one shared 32x32 multiplier and reduces it to a bucket; it
// takes a new command only after pushing the last one into the queue, and
// stalls while the queue is full. The back pops an item, reads the bucket
// head, walks the bucket's chain, one entry RAM read per cycle, decides, and
// for a read fetches the point data. Each result is on result_o for one
// cycle with done_o high; there is no backpressure.
// After reset the bucket head RAM is swept to zero, one entry a cycle,
// over all BUCKET_DEPTH entries; busy stays high meanwhile. APB writes are
// taken at any time and should happen only while the block is idle.
module hashed_point_registry_store #(
  parameter int unsigned MAX_ENTRIES  = 1024,
  parameter int unsigned BUCKET_DEPTH = 2048
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  hpr_pkg::req_t                req_i,
  output logic                         done_o,
  output hpr_pkg::rsp_t                result_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [hpr_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  hpr_pkg::cfg_t       cfg_q;
  hpr_pkg::back_stat_t back_stat;
  hpr_pkg::item_t      push_item, head_item;
  logic                push, full, pop, empty;
  logic [2:0]          reg_idx;
  logic                cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      hpr_pkg::REG_BINARY_CAP:   prdata = 32'(cfg_q.capacity[0]);
      hpr_pkg::REG_ANALOG_CAP:   prdata = 32'(cfg_q.capacity[1]);
      hpr_pkg::REG_SETPOINT_CAP: prdata = 32'(cfg_q.capacity[2]);
      hpr_pkg::REG_CONTROL_CAP:  prdata = 32'(cfg_q.capacity[3]);
      hpr_pkg::REG_BUCKET_BITS:  prdata = 32'(cfg_q.bucket_bits);
      default:                   prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        hpr_pkg::REG_BINARY_CAP:   cfg_q.capacity[0] <= pwdata[hpr_pkg::CAP_W-1:0];
        hpr_pkg::REG_ANALOG_CAP:   cfg_q.capacity[1] <= pwdata[hpr_pkg::CAP_W-1:0];
        hpr_pkg::REG_SETPOINT_CAP: cfg_q.capacity[2] <= pwdata[hpr_pkg::CAP_W-1:0];
        hpr_pkg::REG_CONTROL_CAP:  cfg_q.capacity[3] <= pwdata[hpr_pkg::CAP_W-1:0];
        hpr_pkg::REG_BUCKET_BITS:  cfg_q.bucket_bits <= pwdata[3:0];
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  hpr_front #(.BUCKET_DEPTH(BUCKET_DEPTH)) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start),
    .req_i         (req_i),
    .busy_o        (busy),
    .bucket_bits_i (cfg_q.bucket_bits),
    .back_stat_i   (back_stat),
    .push_o        (push),
    .push_item_o   (push_item),
    .full_i        (full)
  );

  hpr_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .full_o      (full),
    .pop_i       (pop),
    .head_o      (head_item),
    .empty_o     (empty)
  );

  hpr_back #(.MAX_ENTRIES(MAX_ENTRIES), .BUCKET_DEPTH(BUCKET_DEPTH)) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .head_i   (head_item),
    .empty_i  (empty),
    .pop_o    (pop),
    .stat_o   (back_stat),
    .done_o   (done_o),
    .result_o (result_o)
  );
endmodule

### hdl/hpr_checker.sv
// Port-level checks of the hashed point registry store, bound to the top.
// Uses hpr_pkg for the result type and status codes.
module hpr_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          start,
  input logic          busy,
  input logic          done_o,
  input hpr_pkg::rsp_t result_o
);
  // an accepted beat makes the front busy once it is taken
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("busy not raised after accept");

  // no two result beats come back to back
  a_done_spaced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("back-to-back result beats");

  a_missing_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && result_o.status == hpr_pkg::ST_MISSING |->
      result_o.kind_out == '0 && result_o.slot_out == '0)
    else $error("missing key reports a point");

  a_data_only_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && result_o.status != hpr_pkg::ST_OK |->
      result_o.value_out == '0 && result_o.stamp_out == '0 &&
      result_o.quality_out == '0)
    else $error("point data on failed command");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> result_o.status == hpr_pkg::ST_OK || result_o.status == hpr_pkg::ST_EXISTS ||
      result_o.status == hpr_pkg::ST_FULL || result_o.status == hpr_pkg::ST_MISSING ||
      result_o.status == hpr_pkg::ST_KIND)
    else $error("undefined status code");
endmodule

bind hashed_point_registry_store hpr_checker u_hpr_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start    (start),
  .busy     (busy),
  .done_o   (done_o),
  .result_o (result_o)
);
